@@ design/b2da_pkg.sv @@
// ---------------------------------------------------------------------------
// b2da_pkg
// types and constants shared by the binary to decimal ascii converter
// ---------------------------------------------------------------------------
package b2da_pkg;

    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(BIN_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CONV,
        D_DONE
    } dab_state_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SIGN,
        E_SKIP,
        E_DIGIT
    } emit_state_t;

    // finished conversion handed from the converter to the emitter
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } conv_t;

endpackage

@@ design/b2da_num_if.sv @@
// ---------------------------------------------------------------------------
// b2da_num_if
// request channel carrying one binary value and its signedness flag
// ---------------------------------------------------------------------------
interface b2da_num_if;

    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        is_signed;

    modport source (output valid, output value, output is_signed, input ready);
    modport sink (input valid, input value, input is_signed, output ready);

endinterface

@@ design/b2da_char_if.sv @@
// ---------------------------------------------------------------------------
// b2da_char_if
// request channel carrying one ascii character and its last marker
// ---------------------------------------------------------------------------
interface b2da_char_if;

    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);

endinterface

@@ design/b2da_dabble.sv @@
// ---------------------------------------------------------------------------
// b2da_dabble
// bit-serial shift-and-add-3 converter, one binary bit per cycle
// ---------------------------------------------------------------------------
module b2da_dabble (
    input  logic                 clk,
    input  logic                 rst_n,
    b2da_num_if.sink             number,
    output logic                 conv_valid,
    input  logic                 conv_ready,
    output b2da_pkg::conv_t      conv
);

    b2da_pkg::dab_state_t              state_reg, state_next;
    logic [b2da_pkg::BIN_W-1:0]        bin_reg, bin_next;
    logic [b2da_pkg::BCD_W-1:0]        bcd_reg, bcd_next;
    logic [b2da_pkg::BCD_W-1:0]        bcd_adj;
    logic [b2da_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              neg_reg, neg_next;
    logic                              is_neg;

    // digits at five or more get three added before each shift
    always_comb
    begin
        for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign is_neg = number.is_signed && number.value[b2da_pkg::BIN_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b2da_pkg::D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        number.ready = 1'b0;
        conv_valid   = 1'b0;
        case (state_reg)
            b2da_pkg::D_IDLE:
            begin
                number.ready = 1'b1;
                if (number.valid)
                begin
                    // magnitude of a negative value, most negative wraps to itself
                    bin_next   = is_neg ? b2da_pkg::BIN_W'(~number.value + 32'd1)
                                        : number.value;
                    bcd_next   = '0;
                    neg_next   = is_neg;
                    cnt_next   = '0;
                    state_next = b2da_pkg::D_CONV;
                end
            end
            b2da_pkg::D_CONV:
            begin
                bcd_next = {bcd_adj[b2da_pkg::BCD_W-2:0], bin_reg[b2da_pkg::BIN_W-1]};
                bin_next = {bin_reg[b2da_pkg::BIN_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == b2da_pkg::CNT_W'(b2da_pkg::BIN_W - 1))
                    state_next = b2da_pkg::D_DONE;
            end
            b2da_pkg::D_DONE:
            begin
                conv_valid = 1'b1;
                if (conv_ready)
                    state_next = b2da_pkg::D_IDLE;
            end
            default:
            begin
                state_next = b2da_pkg::D_IDLE;
            end
        endcase
    end

    assign conv.neg = neg_reg;
    assign conv.bcd = bcd_reg;

    // every digit of a finished conversion is a decimal digit
    property p_digits_decimal;
        @(posedge clk) disable iff (!rst_n)
        state_reg == b2da_pkg::D_DONE |->
            (bcd_reg[39:36] <= 4'd9) && (bcd_reg[35:32] <= 4'd9) &&
            (bcd_reg[31:28] <= 4'd9) && (bcd_reg[27:24] <= 4'd9) &&
            (bcd_reg[23:20] <= 4'd9) && (bcd_reg[19:16] <= 4'd9) &&
            (bcd_reg[15:12] <= 4'd9) && (bcd_reg[11:8] <= 4'd9) &&
            (bcd_reg[7:4] <= 4'd9) && (bcd_reg[3:0] <= 4'd9);
    endproperty
    a_digits_decimal: assert property (p_digits_decimal)
        else $error("bcd digit out of range");

    // a finished conversion has consumed every binary bit
    a_bin_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == b2da_pkg::D_DONE |-> bin_reg == '0)
        else $error("binary bits left after conversion");

    // conversion only ends after the last shift step
    a_done_after_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == b2da_pkg::D_DONE) |->
            $past(cnt_reg) == b2da_pkg::CNT_W'(b2da_pkg::BIN_W - 1))
        else $error("conversion ended early");

endmodule

@@ design/b2da_emit.sv @@
// ---------------------------------------------------------------------------
// b2da_emit
// shifts bcd digits out as ascii, one per cycle while the text side takes them, suppressing leading zeros
// ---------------------------------------------------------------------------
module b2da_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 conv_valid,
    output logic                 conv_ready,
    input  b2da_pkg::conv_t      conv,
    b2da_char_if.source          text
);

    b2da_pkg::emit_state_t             state_reg, state_next;
    logic [b2da_pkg::BCD_W-1:0]        dig_reg, dig_next;
    logic [b2da_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic                              out_valid_reg, out_valid_next;
    logic [7:0]                        char_reg, char_next;
    logic                              last_reg, last_next;
    logic                              can_load;
    logic [3:0]                        top_digit;

    assign top_digit = dig_reg[b2da_pkg::BCD_W-1 -: 4];
    assign can_load  = !out_valid_reg || text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b2da_pkg::E_IDLE;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        dig_next       = dig_reg;
        rem_next       = rem_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = text.ready ? 1'b0 : out_valid_reg;
        conv_ready     = 1'b0;
        case (state_reg)
            b2da_pkg::E_IDLE:
            begin
                conv_ready = 1'b1;
                if (conv_valid)
                begin
                    dig_next   = conv.bcd;
                    rem_next   = b2da_pkg::REM_W'(b2da_pkg::NUM_DIGITS);
                    state_next = conv.neg ? b2da_pkg::E_SIGN : b2da_pkg::E_SKIP;
                end
            end
            b2da_pkg::E_SIGN:
            begin
                if (can_load)
                begin
                    char_next      = b2da_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = b2da_pkg::E_SKIP;
                end
            end
            b2da_pkg::E_SKIP:
            begin
                // drop leading zeros but always keep the units digit
                if (top_digit == 4'd0 && rem_reg > b2da_pkg::REM_W'(1))
                begin
                    dig_next = {dig_reg[b2da_pkg::BCD_W-5:0], 4'd0};
                    rem_next = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = b2da_pkg::E_DIGIT;
                end
            end
            b2da_pkg::E_DIGIT:
            begin
                if (can_load)
                begin
                    char_next      = b2da_pkg::CHAR_ZERO + {4'd0, top_digit};
                    last_next      = (rem_reg == b2da_pkg::REM_W'(1));
                    out_valid_next = 1'b1;
                    dig_next       = {dig_reg[b2da_pkg::BCD_W-5:0], 4'd0};
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == b2da_pkg::REM_W'(1))
                        state_next = b2da_pkg::E_IDLE;
                end
            end
            default:
            begin
                state_next = b2da_pkg::E_IDLE;
            end
        endcase
    end

    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    // only a minus sign or a decimal digit ever leaves
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == b2da_pkg::CHAR_MINUS) ||
            ((char_reg >= b2da_pkg::CHAR_ZERO) && (char_reg <= b2da_pkg::CHAR_NINE)))
        else $error("illegal character");

    // a minus sign is never the last character
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && char_reg == b2da_pkg::CHAR_MINUS |-> !last_reg)
        else $error("sign marked last");

    // digit emission never runs past the digit count
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == b2da_pkg::E_DIGIT || state_reg == b2da_pkg::E_SKIP) |->
            rem_reg != '0)
        else $error("digit count underflow");

    // a negative result starts with the sign step
    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        conv_valid && conv_ready |=>
            ((state_reg == b2da_pkg::E_SIGN) == $past(conv.neg)))
        else $error("sign step mismatch");

endmodule

@@ design/binary_to_decimal_ascii.sv @@
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// 32-bit signed or unsigned binary to decimal ascii text, one char per request
// ---------------------------------------------------------------------------
//
//  channel   dir   payload                           handshake
//  --------  ----  --------------------------------  -----------
//  number    in    value[31:0], is_signed            valid/ready
//  text      out   character[7:0], last              valid/ready
//
//  a number passes through the converter as a load, 32 shift-and-add-3
//  steps (one binary bit per cycle) and a handoff to the emitter
//  emission then skips up to 9 leading zeros (one digit per cycle) and
//  sends 1 to 11 characters
//  the converter takes the next number while the emitter still drains text
//  rst_n clears the control state of both halves, no clearing pass
//  a stalled text request holds in the output register and stops emission
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii (
    input  logic         clk,
    input  logic         rst_n,
    b2da_num_if.sink     number,
    b2da_char_if.source  text
);

    // handoff between the bit-serial converter and the digit emitter
    logic             conv_valid;
    logic             conv_ready;
    b2da_pkg::conv_t  conv;

    // binary magnitude to packed bcd, one bit per cycle
    b2da_dabble u_dabble (
        .clk        (clk),
        .rst_n      (rst_n),
        .number     (number),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready),
        .conv       (conv)
    );

    // sign, zero suppression and ascii output register
    b2da_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready),
        .conv       (conv),
        .text       (text)
    );

    // the converter never holds a result the emitter has already taken
    a_handoff_once: assert property (@(posedge clk) disable iff (!rst_n)
        conv_valid && conv_ready |=> !conv_valid)
        else $error("conversion handed off twice");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// checks the binary to decimal ascii converter against its own text predictor
// directed edge values, back-to-back traffic, a long text stall, a drain pause
// and a long random stream, with random idling on both channels
// ---------------------------------------------------------------------------
module tb_top;

    // no-acceptance cycles before the run is declared hung; the limit sits
    // well above the slowest correct number plus the sink hold
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SINK_HOLD_CYCLES = 300;
    // covers one more conversion, its leading-zero skips and up to 11 characters
    localparam int DRAIN_CYCLES     = 80;
    localparam int MAX_REPORTS      = 10;
    localparam logic [31:0] DIGIT_BASE = 32'd10;

    // one expected text request
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    b2da_num_if  num_ch ();
    b2da_char_if text_ch ();

    binary_to_decimal_ascii uut (
        .clk   (clk),
        .rst_n (rst_n),
        .number(num_ch),
        .text  (text_ch)
    );

    // characters still owed by the block, oldest first
    text_char_t expected_text[$];
    int         error_count = 0;

    // idling switches, written by the test sequence only
    logic sender_idles = 1'b1;
    logic sink_idles = 1'b1;

    // toggled by the test sequence to start a long hold on the text side
    logic sink_hold_req = 1'b0;
    logic sink_hold_seen = 1'b0;
    int   sink_hold_left = 0;

    int   quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: decimal text of one number, most significant digit first
    // ------------------------------------------------------------------------
    function automatic void predict_decimal_text(input logic [31:0] value,
                                                 input logic is_signed);
        logic [31:0] magnitude;
        logic [3:0]  digit_list [b2da_pkg::NUM_DIGITS];
        int          count;
        magnitude = value;
        count = 0;
        // negative signed value: sign first, then the magnitude; the most
        // negative value wraps to 2147483648 in 32-bit unsigned arithmetic
        if (is_signed && value[31])
        begin
            magnitude = ~value + 32'd1;
            expected_text.push_back(text_char_t'{b2da_pkg::CHAR_MINUS, 1'b0});
        end
        // at least one digit, so zero gives a lone '0'
        do
        begin
            digit_list[count] = 4'(magnitude % DIGIT_BASE);
            count++;
            magnitude = magnitude / DIGIT_BASE;
        end while (magnitude != 0 && count < b2da_pkg::NUM_DIGITS);
        while (count > 0)
        begin
            count--;
            expected_text.push_back(
                text_char_t'{b2da_pkg::CHAR_ZERO + 8'(digit_list[count]), count == 0});
        end
    endfunction

    // spread over every text length, near powers of ten and the sign edges
    function automatic logic [31:0] random_number_value();
        logic [31:0] pow10;
        pow10 = 32'd1;
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom >> $urandom_range(31);
            2:
            begin
                repeat ($urandom_range(9)) pow10 = pow10 * DIGIT_BASE;
                return pow10 + $urandom_range(2) - 32'd1;
            end
            // negated shifted values, mostly small negatives when read as signed
            3: return ~($urandom >> $urandom_range(31)) + 32'd1;
            4:
            begin
                case ($urandom_range(2))
                    0: return 32'h8000_0000 + $urandom_range(3);
                    1: return 32'h7FFF_FFFF - $urandom_range(3);
                    default: return 32'hFFFF_FFFF - $urandom_range(3);
                endcase
            end
            default: return $urandom_range(9);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // number side: one request per call, valid stays high into the next call
    // so back-to-back requests never see valid dropped and raised in a step
    // ------------------------------------------------------------------------
    task automatic send_number(input logic [31:0] value, input logic is_signed);
        while (sender_idles && $urandom_range(99) < 15)
        begin
            num_ch.valid <= 1'b0;
            @(posedge clk);
        end
        num_ch.valid     <= 1'b1;
        num_ch.value     <= value;
        num_ch.is_signed <= is_signed;
        @(posedge clk);
        while (!num_ch.ready) @(posedge clk);
    endtask

    task automatic send_random_numbers(input int n);
        repeat (n) send_number(random_number_value(), 1'($urandom_range(1)));
    endtask

    // expectations are queued at the edge where a number request is taken
    always @(posedge clk)
    begin
        if (rst_n && num_ch.valid && num_ch.ready)
            predict_decimal_text(num_ch.value, num_ch.is_signed);
    end

    // ------------------------------------------------------------------------
    // text side: random ready, with an on-demand long hold counted here
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_ch.ready  <= 1'b0;
            sink_hold_left <= 0;
        end
        else if (sink_hold_req != sink_hold_seen)
        begin
            sink_hold_seen <= sink_hold_req;
            sink_hold_left <= SINK_HOLD_CYCLES;
            text_ch.ready  <= 1'b0;
        end
        else if (sink_hold_left != 0)
        begin
            sink_hold_left <= sink_hold_left - 1;
            text_ch.ready  <= 1'b0;
        end
        else
            text_ch.ready <= !sink_idles || ($urandom_range(99) >= 15);
    end

    // compare each accepted character with the oldest expectation
    always @(posedge clk)
    begin
        text_char_t got;
        text_char_t want;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            got = text_char_t'{text_ch.character, text_ch.last};
            if (expected_text.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected character %h last %b",
                             $time, got.character, got.last);
            end
            else
            begin
                want = expected_text.pop_front();
                if (got.character !== want.character || got.last !== want.last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: character exp %h got %h, last exp %b got %b",
                                 $time, want.character, got.character,
                                 want.last, got.last);
                end
            end
        end
    end

    // hang detection: any accepted request on either side restarts the count
    always @(posedge clk)
    begin
        if ((num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // edges of both fields: zero, single digits, powers of ten, all ones,
    // the most negative value and its unsigned twin, the sign boundary
    task automatic test_directed_values();
        send_number(32'd0, 1'b0);
        send_number(32'd0, 1'b1);
        send_number(32'd1, 1'b0);
        send_number(32'd9, 1'b1);
        send_number(32'd10, 1'b0);
        send_number(32'd99, 1'b1);
        send_number(32'd100, 1'b0);
        send_number(32'd999_999_999, 1'b0);
        send_number(32'd1_000_000_000, 1'b1);
        send_number(32'd4_000_000_000, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b1);
        send_number(32'h8000_0000, 1'b1);
        send_number(32'h8000_0000, 1'b0);
        send_number(32'h8000_0001, 1'b1);
        send_number(32'h7FFF_FFFF, 1'b1);
        send_number(32'h7FFF_FFFF, 1'b0);
        send_number(32'hFFFF_FFF6, 1'b1);
        send_number(32'hFFFF_FFF7, 1'b1);
        send_number(32'hAAAA_AAAA, 1'b0);
        send_number(32'h5555_5555, 1'b1);
    endtask

    // no idling at all on either side
    task automatic test_back_to_back();
        sender_idles <= 1'b0;
        sink_idles   <= 1'b0;
        send_random_numbers(40);
        sender_idles <= 1'b1;
        sink_idles   <= 1'b1;
    endtask

    // text side held for a long stretch while numbers keep coming, so the
    // block fills and pushes back on the number side
    task automatic test_sink_hold();
        sink_hold_req <= ~sink_hold_req;
        send_random_numbers(20);
    endtask

    // sender stops until every owed character has come out
    task automatic test_sender_pause();
        send_random_numbers(10);
        num_ch.valid <= 1'b0;
        // let the predictor queue the last request first
        @(posedge clk);
        while (expected_text.size() != 0) @(posedge clk);
        send_random_numbers(10);
    endtask

    task automatic test_random_stream();
        send_random_numbers(260);
    endtask

    initial
    begin
        num_ch.valid     = 1'b0;
        num_ch.value     = '0;
        num_ch.is_signed = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_back_to_back();
        test_sink_hold();
        test_sender_pause();
        test_random_stream();

        // drop the last request, let everything owed come out, then linger
        num_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_text.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_text.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
design/b2da_pkg.sv
design/b2da_num_if.sv
design/b2da_char_if.sv
design/b2da_dabble.sv
design/b2da_emit.sv
design/binary_to_decimal_ascii.sv
bench/tb_top.sv
